// ===== design/ptalloc_pkg.sv =====
// Shared types and codes for the process table allocator.
// Used by the front end, the back end and the top level; depends on nothing.
package ptalloc_pkg;

	localparam int OP_W     = 2;
	localparam int ENTRY_W  = 6;
	localparam int STATUS_W = 3;

	localparam logic [OP_W-1:0] OP_ALLOC    = 2'd0;
	localparam logic [OP_W-1:0] OP_DELETE   = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY    = 2'd2;
	// The last code is reserved; it is answered with zeros and changes nothing.
	localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY        = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_IN_USE   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_HAS_CHILDREN = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NO_CHILDREN  = 3'd4;

	// A classified request as it travels from the front end to the back end.
	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [ENTRY_W-1:0] entry;
		logic               oor;
	} req_t;

endpackage

// ===== design/process_table_allocator.sv =====
// Channel   Handshake              Fields
// request   req_valid / req_stall  operation, entry
// response  rsp_valid / rsp_stall  status, result_entry
//
// Allocate, query, unknown operations and refused items finish in the back
// end's first execute state; a delete that goes ahead also needs the second,
// as each step waits on one dependent registered table read. After reset the
// back end resets all POOL_SIZE (64) entries; up to two items queue meanwhile.
// A two-slot queue lets requests arrive while the back end works, and a
// result register lets the next item start while a result is stalled.
module process_table_allocator #(
	parameter int POOL_SIZE = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	output logic                               req_stall,
	input  logic [ptalloc_pkg::OP_W-1:0]       operation,
	input  logic [ptalloc_pkg::ENTRY_W-1:0]    entry,
	output logic                               rsp_valid,
	input  logic                               rsp_stall,
	output logic [ptalloc_pkg::STATUS_W-1:0]   status,
	output logic [ptalloc_pkg::ENTRY_W-1:0]    result_entry
);
	import ptalloc_pkg::*;

	logic q_valid, q_pop;
	req_t q_req;

	ptalloc_front #(.POOL_SIZE(POOL_SIZE)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid     (req_valid),
		.stall     (req_stall),
		.operation (operation),
		.entry     (entry),
		.q_valid   (q_valid),
		.q_req     (q_req),
		.q_pop     (q_pop)
	);

	ptalloc_back #(.POOL_SIZE(POOL_SIZE)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_req        (q_req),
		.q_pop        (q_pop),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.status       (status),
		.result_entry (result_entry)
	);

endmodule

// ===== design/ptalloc_ram.sv =====
// Generic single-write, single-read memory with a registered read port.
// No dependencies; every pointer table of the allocator is one of these.
module ptalloc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== design/ptalloc_front.sv =====
// Front end: accepts request items, classifies them and holds them in a
// two-slot queue for the back end. Depends on ptalloc_pkg.
module ptalloc_front #(
	parameter int POOL_SIZE = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               valid,
	output logic                               stall,
	input  logic [ptalloc_pkg::OP_W-1:0]       operation,
	input  logic [ptalloc_pkg::ENTRY_W-1:0]    entry,
	output logic                               q_valid,
	output ptalloc_pkg::req_t                  q_req,
	input  logic                               q_pop
);
	import ptalloc_pkg::*;

	req_t       slot_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push, pop;
	req_t       req_in;

	// An entry index at or above the pool size never names a live entry.
	always_comb begin
		req_in.op    = operation;
		req_in.entry = entry;
		req_in.oor   = (32'(entry) >= POOL_SIZE);
	end

	assign stall   = (cnt_q == 2'd2);
	assign push    = valid && !stall;
	assign q_valid = (cnt_q != 2'd0);
	assign pop     = q_pop && q_valid;
	assign q_req   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= req_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// ===== design/ptalloc_back.sv =====
// Back end: runs one queued item at a time against the pointer tables and
// the free queue, and holds the result item for the response channel.
// Depends on ptalloc_pkg and ptalloc_ram.
module ptalloc_back #(
	parameter int POOL_SIZE = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               q_valid,
	input  ptalloc_pkg::req_t                  q_req,
	output logic                               q_pop,
	output logic                               rsp_valid,
	input  logic                               rsp_stall,
	output logic [ptalloc_pkg::STATUS_W-1:0]   status,
	output logic [ptalloc_pkg::ENTRY_W-1:0]    result_entry
);
	import ptalloc_pkg::*;

	localparam int IW   = $clog2(POOL_SIZE);
	localparam int LW   = IW + 1;
	localparam int CNTW = $clog2(POOL_SIZE + 1);
	localparam logic [LW-1:0] NONE = LW'(POOL_SIZE);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EX1  = 2'd1;
	localparam logic [1:0] S_EX2  = 2'd2;
	localparam logic [1:0] S_CLR  = 2'd3;

	function automatic logic is_link(input logic [LW-1:0] v);
		return v < NONE;
	endfunction

	logic [1:0]          state_q, state_d;
	logic [IW-1:0]       clr_q;
	req_t                cur_q;
	logic [IW-1:0]       p_q;
	logic [LW-1:0]       nx_q, pv_q;
	logic [IW-1:0]       head_q;
	logic [CNTW-1:0]     count_q;
	logic                rsp_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [IW-1:0]       result_q;

	logic [IW-1:0] rd_idx, cur_idx;
	logic          use_v;
	logic [IW-1:0] par_v, fq_v;
	logic [LW-1:0] nxt_v, prv_v, fch_v, lch_v;

	logic          use_we, use_wdata;
	logic          par_we, nxt_we, prv_we, fch_we, lch_we, fq_we;
	logic [IW-1:0] use_waddr;
	logic [IW-1:0] par_waddr, nxt_waddr, prv_waddr, fch_waddr, lch_waddr, fq_waddr;
	logic [IW-1:0] par_wdata, fq_wdata;
	logic [LW-1:0] nxt_wdata, prv_wdata, fch_wdata, lch_wdata;

	logic          live, out_free, finish, go_ex2, fire_alloc, fire_del;
	logic [STATUS_W-1:0] st_d;
	logic [IW-1:0] res_d;
	logic [IW:0]   tail_sum;
	logic [IW-1:0] tail, head_inc;

	assign cur_idx  = IW'(cur_q.entry);
	assign live     = !cur_q.oor && use_v;
	assign out_free = !rsp_valid_q || !rsp_stall;

	// Read addresses are held while an item waits so the registered read
	// data stays valid across output stalls. A delete that goes ahead moves
	// on to its parent's entry for the second execute state.
	always_comb begin
		case (state_q)
			S_EX1:   rd_idx = go_ex2 ? par_v : cur_idx;
			S_EX2:   rd_idx = p_q;
			default: rd_idx = IW'(q_req.entry);
		endcase
	end

	assign tail_sum = {1'b0, head_q} + (IW+1)'(count_q);
	assign tail     = (tail_sum >= (IW+1)'(POOL_SIZE)) ?
		IW'(tail_sum - (IW+1)'(POOL_SIZE)) : IW'(tail_sum);
	assign head_inc = (head_q == IW'(POOL_SIZE - 1)) ? '0 : head_q + 1'b1;

	always_comb begin
		state_d    = state_q;
		q_pop      = 1'b0;
		finish     = 1'b0;
		go_ex2     = 1'b0;
		fire_alloc = 1'b0;
		fire_del   = 1'b0;
		st_d       = ST_OK;
		res_d      = '0;
		case (state_q)
			S_CLR: begin
				if (clr_q == IW'(POOL_SIZE - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					state_d = S_EX1;
				end
			end
			S_EX1: begin
				case (cur_q.op)
					OP_ALLOC: begin
						finish = 1'b1;
						if (!live) begin
							st_d = ST_NOT_IN_USE;
						end else if (count_q == '0) begin
							st_d = ST_EMPTY;
						end else begin
							res_d      = fq_v;
							fire_alloc = out_free;
						end
					end
					OP_DELETE: begin
						if (!live) begin
							st_d   = ST_NOT_IN_USE;
							finish = 1'b1;
						end else if (is_link(fch_v)) begin
							st_d   = ST_HAS_CHILDREN;
							finish = 1'b1;
						end else begin
							go_ex2  = 1'b1;
							state_d = S_EX2;
						end
					end
					OP_QUERY: begin
						finish = 1'b1;
						if (!live) begin
							st_d = ST_NOT_IN_USE;
						end else if (!is_link(fch_v)) begin
							st_d = ST_NO_CHILDREN;
						end else begin
							res_d = IW'(fch_v);
						end
					end
					default: begin
						finish = 1'b1;
					end
				endcase
			end
			S_EX2: begin
				finish   = 1'b1;
				fire_del = out_free;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (finish && out_free) begin
			state_d = S_IDLE;
		end
	end

	// Table updates. An entry in the free queue always has no children and
	// no siblings, so an allocate only writes the links that change.
	always_comb begin
		use_we = 1'b0; use_waddr = '0; use_wdata = 1'b0;
		par_we = 1'b0; par_waddr = '0; par_wdata = '0;
		nxt_we = 1'b0; nxt_waddr = '0; nxt_wdata = '0;
		prv_we = 1'b0; prv_waddr = '0; prv_wdata = '0;
		fch_we = 1'b0; fch_waddr = '0; fch_wdata = '0;
		lch_we = 1'b0; lch_waddr = '0; lch_wdata = '0;
		fq_we  = 1'b0; fq_waddr  = '0; fq_wdata  = '0;
		if (state_q == S_CLR) begin
			use_we    = 1'b1;
			use_waddr = clr_q;
			use_wdata = (clr_q == '0);
			par_we    = 1'b1;
			par_waddr = clr_q;
			nxt_we    = 1'b1;
			nxt_waddr = clr_q;
			nxt_wdata = NONE;
			prv_we    = 1'b1;
			prv_waddr = clr_q;
			prv_wdata = NONE;
			fch_we    = 1'b1;
			fch_waddr = clr_q;
			fch_wdata = NONE;
			lch_we    = 1'b1;
			lch_waddr = clr_q;
			lch_wdata = NONE;
			fq_we     = 1'b1;
			fq_waddr  = clr_q;
			fq_wdata  = (clr_q == IW'(POOL_SIZE - 1)) ? '0 : IW'(POOL_SIZE - 1) - clr_q;
		end
		if (fire_alloc) begin
			use_we    = 1'b1;
			use_waddr = fq_v;
			use_wdata = 1'b1;
			par_we    = 1'b1;
			par_waddr = fq_v;
			par_wdata = cur_idx;
			if (is_link(lch_v)) begin
				nxt_we    = 1'b1;
				nxt_waddr = IW'(lch_v);
				nxt_wdata = {1'b0, fq_v};
			end else begin
				fch_we    = 1'b1;
				fch_waddr = cur_idx;
				fch_wdata = {1'b0, fq_v};
			end
			prv_we    = 1'b1;
			prv_waddr = fq_v;
			prv_wdata = lch_v;
			lch_we    = 1'b1;
			lch_waddr = cur_idx;
			lch_wdata = {1'b0, fq_v};
		end
		// The deleted entry's own sibling links are dropped in the first execute
		// state, at the edge that captures them.
		if (go_ex2) begin
			nxt_we    = 1'b1;
			nxt_waddr = cur_idx;
			nxt_wdata = NONE;
			prv_we    = 1'b1;
			prv_waddr = cur_idx;
			prv_wdata = NONE;
		end
		if (fire_del) begin
			use_we    = 1'b1;
			use_waddr = cur_idx;
			use_wdata = 1'b0;
			if (is_link(pv_q)) begin
				nxt_we    = 1'b1;
				nxt_waddr = IW'(pv_q);
				nxt_wdata = nx_q;
			end else if (fch_v == {1'b0, cur_idx}) begin
				fch_we    = 1'b1;
				fch_waddr = p_q;
				fch_wdata = nx_q;
			end
			if (is_link(nx_q)) begin
				prv_we    = 1'b1;
				prv_waddr = IW'(nx_q);
				prv_wdata = pv_q;
			end else if (lch_v == {1'b0, cur_idx}) begin
				lch_we    = 1'b1;
				lch_waddr = p_q;
				lch_wdata = pv_q;
			end
			if (count_q < CNTW'(POOL_SIZE)) begin
				fq_we    = 1'b1;
				fq_waddr = tail;
				fq_wdata = cur_idx;
			end
		end
	end

	ptalloc_ram #(.WIDTH(1), .DEPTH(POOL_SIZE)) u_use (
		.clk(clk), .we(use_we), .waddr(use_waddr), .wdata(use_wdata),
		.raddr(rd_idx), .rdata(use_v)
	);
	ptalloc_ram #(.WIDTH(IW), .DEPTH(POOL_SIZE)) u_par (
		.clk(clk), .we(par_we), .waddr(par_waddr), .wdata(par_wdata),
		.raddr(rd_idx), .rdata(par_v)
	);
	ptalloc_ram #(.WIDTH(LW), .DEPTH(POOL_SIZE)) u_nxt (
		.clk(clk), .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
		.raddr(rd_idx), .rdata(nxt_v)
	);
	ptalloc_ram #(.WIDTH(LW), .DEPTH(POOL_SIZE)) u_prv (
		.clk(clk), .we(prv_we), .waddr(prv_waddr), .wdata(prv_wdata),
		.raddr(rd_idx), .rdata(prv_v)
	);
	ptalloc_ram #(.WIDTH(LW), .DEPTH(POOL_SIZE)) u_fch (
		.clk(clk), .we(fch_we), .waddr(fch_waddr), .wdata(fch_wdata),
		.raddr(rd_idx), .rdata(fch_v)
	);
	ptalloc_ram #(.WIDTH(LW), .DEPTH(POOL_SIZE)) u_lch (
		.clk(clk), .we(lch_we), .waddr(lch_waddr), .wdata(lch_wdata),
		.raddr(rd_idx), .rdata(lch_v)
	);
	ptalloc_ram #(.WIDTH(IW), .DEPTH(POOL_SIZE)) u_fq (
		.clk(clk), .we(fq_we), .waddr(fq_waddr), .wdata(fq_wdata),
		.raddr(head_q), .rdata(fq_v)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			head_q      <= '0;
			count_q     <= CNTW'(POOL_SIZE - 1);
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (fire_alloc) begin
				head_q  <= head_inc;
				count_q <= count_q - 1'b1;
			end
			if (fire_del && fq_we) begin
				count_q <= count_q + 1'b1;
			end
			if (finish && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_req;
		end
		if (go_ex2) begin
			p_q  <= par_v;
			nx_q <= nxt_v;
			pv_q <= prv_v;
		end
		if (finish && out_free) begin
			status_q <= st_d;
			result_q <= res_d;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign status       = status_q;
	assign result_entry = ENTRY_W'(result_q);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNTW'(POOL_SIZE))
		else $error("free count exceeds pool size");

	a_alloc_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		fire_alloc |-> count_q != '0)
		else $error("allocate taken from an empty free queue");

	a_clr_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLR |-> !q_pop)
		else $error("item taken while the tables are being cleared");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_stall |=>
			rsp_valid_q && $stable(status_q) && $stable(result_q))
		else $error("stalled result item changed");

	a_ex2_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EX2 |-> $past(state_q) == S_EX1 || $past(state_q) == S_EX2)
		else $error("second delete cycle entered out of order");

endmodule

// ===== test/ptalloc_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the process table allocator: keeps its own copy of the entry tree
// and the free queue, predicts one result item per request item and compares them.
// Depends on ptalloc_pkg for the field widths and the operation and status codes.
module ptalloc_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	input  logic                               req_stall,
	input  logic [ptalloc_pkg::OP_W-1:0]       operation,
	input  logic [ptalloc_pkg::ENTRY_W-1:0]    entry,
	input  logic                               rsp_valid,
	input  logic                               rsp_stall,
	input  logic [ptalloc_pkg::STATUS_W-1:0]   status,
	input  logic [ptalloc_pkg::ENTRY_W-1:0]    result_entry,
	output int                                 fail_count,
	output int                                 outstanding
);
	import ptalloc_pkg::*;

	localparam int POOL = 64;
	localparam logic [6:0] NO_LINK = 7'd64;

	typedef struct packed {
		logic [STATUS_W-1:0] st;
		logic [ENTRY_W-1:0]  idx;
	} reply_t;

	logic       used      [POOL];
	logic [5:0] parent    [POOL];
	logic [6:0] nxt       [POOL];
	logic [6:0] prv       [POOL];
	logic [6:0] head_kid  [POOL];
	logic [6:0] tail_kid  [POOL];
	logic [5:0] free_slot [POOL];
	logic [5:0] free_rd;
	logic [6:0] free_num;
	reply_t     replies_q [$];

	function automatic bit linked(input logic [6:0] v);
		return v < NO_LINK;
	endfunction

	task automatic clear_tables();
		for (int k = 0; k < POOL; k++) begin
			used[k] = 1'b0;
			parent[k] = '0;
			nxt[k] = NO_LINK;
			prv[k] = NO_LINK;
			head_kid[k] = NO_LINK;
			tail_kid[k] = NO_LINK;
			free_slot[k] = (k < POOL - 1) ? 6'(POOL - 1 - k) : 6'd0;
		end
		used[0] = 1'b1;
		free_rd = '0;
		free_num = 7'(POOL - 1);
	endtask

	// Applies one request item to the shadow tables and returns its result item.
	task automatic apply_request(input logic [OP_W-1:0] op, input logic [ENTRY_W-1:0] e,
			output reply_t r);
		logic [5:0] n;
		logic [5:0] p;
		logic [5:0] slot;
		logic [6:0] nx;
		logic [6:0] pv;
		bit         live;
		r.st = ST_OK;
		r.idx = '0;
		live = (int'(e) < POOL) && used[e];
		case (op)
			OP_ALLOC: begin
				if (!live) begin
					r.st = ST_NOT_IN_USE;
				end else if (free_num == 0) begin
					r.st = ST_EMPTY;
				end else begin
					n = free_slot[free_rd];
					free_rd = free_rd + 6'd1;
					free_num = free_num - 7'd1;
					used[n] = 1'b1;
					parent[n] = e;
					head_kid[n] = NO_LINK;
					tail_kid[n] = NO_LINK;
					nxt[n] = NO_LINK;
					prv[n] = tail_kid[e];
					if (linked(tail_kid[e]))
						nxt[tail_kid[e][5:0]] = {1'b0, n};
					else
						head_kid[e] = {1'b0, n};
					tail_kid[e] = {1'b0, n};
					r.idx = n;
				end
			end
			OP_DELETE: begin
				if (!live) begin
					r.st = ST_NOT_IN_USE;
				end else if (linked(head_kid[e])) begin
					r.st = ST_HAS_CHILDREN;
				end else begin
					p = parent[e];
					nx = nxt[e];
					pv = prv[e];
					if (linked(pv))
						nxt[pv[5:0]] = nx;
					else if (head_kid[p] == {1'b0, e})
						head_kid[p] = nx;
					if (linked(nx))
						prv[nx[5:0]] = pv;
					else if (tail_kid[p] == {1'b0, e})
						tail_kid[p] = pv;
					nxt[e] = NO_LINK;
					prv[e] = NO_LINK;
					used[e] = 1'b0;
					if (free_num < POOL) begin
						slot = free_rd + free_num[5:0];
						free_slot[slot] = e;
						free_num = free_num + 7'd1;
					end
				end
			end
			OP_QUERY: begin
				if (!live)
					r.st = ST_NOT_IN_USE;
				else if (!linked(head_kid[e]))
					r.st = ST_NO_CHILDREN;
				else
					r.idx = head_kid[e][5:0];
			end
			default: begin
				// Unknown codes leave the tables alone and answer with zeros.
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		reply_t want;
		if (!arst_n) begin
			clear_tables();
			replies_q.delete();
			fail_count = 0;
			outstanding = 0;
		end else begin
			// The older item leaves first, so compare before the new prediction goes in.
			if (rsp_valid && !rsp_stall) begin
				if (replies_q.size() == 0) begin
					$display("%0t: result item with nothing expected: status %0d entry %0d",
						$time, status, result_entry);
					fail_count++;
				end else begin
					want = replies_q.pop_front();
					if (status !== want.st) begin
						$display("%0t: status expected %0d actual %0d", $time, want.st, status);
						fail_count++;
					end
					if (result_entry !== want.idx) begin
						$display("%0t: result_entry expected %0d actual %0d",
							$time, want.idx, result_entry);
						fail_count++;
					end
				end
			end
			if (req_valid && !req_stall) begin
				apply_request(operation, entry, want);
				replies_q.push_back(want);
			end
			outstanding = replies_q.size();
		end
	end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// Top of the process table allocator testbench: clock, reset, request items and
// result-side stalls, and the verdict. Depends on ptalloc_pkg, the block and ptalloc_checker.
module tb;
	import ptalloc_pkg::*;

	localparam int RUN_LIMIT    = 400000;
	localparam int RANDOM_ITEMS = 1030;
	localparam int POOL         = 64;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_stall;
	logic [OP_W-1:0]     operation = OP_ALLOC;
	logic [ENTRY_W-1:0]  entry = '0;
	logic                rsp_valid;
	logic                rsp_stall = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [ENTRY_W-1:0]  result_entry;
	int                  fail_count;
	int                  outstanding;
	int                  cycles = 0;
	bit                  idle_en = 1'b0;
	int                  stall_hold = 0;

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [ENTRY_W-1:0] e;
	} sent_t;

	// What the stimulus knows of the tree, learned from the result items. It lags
	// behind by the items in flight, which only makes some choices miss.
	sent_t      sent_q [$];
	bit         alive  [POOL];
	logic [5:0] up     [POOL];
	int         kids   [POOL];

	process_table_allocator u_top (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall),
		.operation(operation), .entry(entry),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.status(status), .result_entry(result_entry)
	);

	ptalloc_checker u_check (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall),
		.operation(operation), .entry(entry),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.status(status), .result_entry(result_entry),
		.fail_count(fail_count), .outstanding(outstanding)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == RUN_LIMIT) begin
			$display("[process_table_allocator] ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (!idle_en) begin
			rsp_stall <= 1'b0;
			stall_hold <= 0;
		end else if (stall_hold > 1) begin
			stall_hold <= stall_hold - 1;
		end else if (stall_hold == 1) begin
			stall_hold <= 0;
			rsp_stall <= 1'b0;
		end else if ($urandom_range(0, 6) == 0) begin
			rsp_stall <= 1'b1;
			stall_hold <= $urandom_range(1, 18);
		end
	end

	always @(posedge clk) begin : learn
		sent_t s;
		if (rsp_valid && !rsp_stall && sent_q.size() != 0) begin
			s = sent_q.pop_front();
			if (status == ST_OK && s.op == OP_ALLOC) begin
				alive[result_entry] <= 1'b1;
				up[result_entry] <= s.e;
				kids[s.e] <= kids[s.e] + 1;
			end else if (status == ST_OK && s.op == OP_DELETE) begin
				alive[s.e] <= 1'b0;
				if (s.e != 0)
					kids[up[s.e]] <= kids[up[s.e]] - 1;
			end
		end
	end

	// Random entry in use as far as the stimulus knows, or -1 when there is none.
	function automatic int pick(input bit skip_root, input bit leaf_only);
		int cand [$];
		for (int k = 0; k < POOL; k++)
			if (alive[k] && !(skip_root && k == 0) && !(leaf_only && kids[k] != 0))
				cand.push_back(k);
		if (cand.size() == 0)
			return -1;
		return cand[$urandom_range(0, cand.size() - 1)];
	endfunction

	task automatic send(input logic [OP_W-1:0] op, input logic [ENTRY_W-1:0] e);
		if (idle_en && $urandom_range(0, 4) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		req_valid <= 1'b1;
		operation <= op;
		entry <= e;
		do @(posedge clk); while (req_stall);
		sent_q.push_back('{op: op, e: e});
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (sent_q.size() != 0 || outstanding != 0)
			@(posedge clk);
	endtask

	// Growing phases mostly allocate until the pool runs dry; shrinking phases
	// mostly remove leaves. The root is never deleted here, since that would
	// leave nothing in use for good.
	task automatic random_item(input bit growing);
		logic [OP_W-1:0] op;
		int k;
		int r;
		r = $urandom_range(0, 99);
		if (r < (growing ? 65 : 15)) begin
			op = OP_ALLOC;
			k = pick(1'b0, 1'b0);
		end else if (r < (growing ? 78 : 65)) begin
			op = OP_DELETE;
			k = pick(1'b1, 1'b1);
		end else if (r < (growing ? 82 : 75)) begin
			op = OP_DELETE;
			k = pick(1'b1, 1'b0);
		end else if (r < 90) begin
			op = OP_QUERY;
			k = pick(1'b0, 1'b0);
		end else begin
			op = OP_W'($urandom_range(0, 3));
			k = $urandom_range(0, POOL - 1);
			if (op == OP_DELETE && k == 0)
				k = 1;
		end
		if (k < 0) begin
			op = OP_QUERY;
			k = 0;
		end
		send(op, ENTRY_W'(k));
	endtask

	initial begin : stimulus
		int rounds;
		bit busy;
		alive[0] = 1'b1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_en <= 1'b1;

		// Directed: first and middle and last child removal, refusals, unknown code.
		send(OP_QUERY, 6'd0);
		send(OP_ALLOC, 6'd0);
		send(OP_ALLOC, 6'd0);
		send(OP_ALLOC, 6'd63);
		send(OP_QUERY, 6'd0);
		send(OP_DELETE, 6'd0);
		send(OP_DELETE, 6'd63);
		send(OP_DELETE, 6'd5);
		send(OP_QUERY, 6'd5);
		send(OP_ALLOC, 6'd5);
		send(OP_RESERVED, 6'd63);
		send(OP_RESERVED, 6'd0);
		send(OP_ALLOC, 6'd0);
		send(OP_DELETE, 6'd62);
		send(OP_QUERY, 6'd0);
		send(OP_DELETE, 6'd61);
		send(OP_QUERY, 6'd63);
		send(OP_DELETE, 6'd63);
		send(OP_QUERY, 6'd0);
		send(OP_DELETE, 6'd60);
		send(OP_QUERY, 6'd0);
		send(OP_ALLOC, 6'd0);
		drain();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 100 == 0)
				idle_en <= (i % 300 != 200) && (i < RANDOM_ITEMS - 150);
			random_item((i / 200) % 2 == 0);
		end
		idle_en <= 1'b0;
		drain();

		// Tear the tree down leaf by leaf, then remove the root itself.
		rounds = 0;
		do begin
			busy = 1'b0;
			for (int k = 1; k < POOL; k++)
				if (alive[k] && kids[k] == 0) begin
					send(OP_DELETE, ENTRY_W'(k));
					busy = 1'b1;
				end
			drain();
			@(posedge clk);
			rounds++;
		end while (busy && rounds < 100);
		send(OP_DELETE, 6'd0);
		send(OP_QUERY, 6'd0);
		send(OP_ALLOC, 6'd0);
		send(OP_ALLOC, 6'd63);
		send(OP_DELETE, 6'd0);
		drain();
		repeat (12) @(posedge clk);

		if (fail_count == 0)
			$display("[process_table_allocator] OK");
		else
			$display("[process_table_allocator] ERROR");
		$finish;
	end

endmodule
